>>> hdl/dkpq_pkg.sv
// Package: record layout, operation and status codes for the descending-key priority queue.
`default_nettype none
package dkpq_pkg;

  localparam int KEY_W   = 31;
  localparam int GRADE_W = 7;
  localparam int STAT_W  = 2;

  typedef struct packed {
    logic [KEY_W-1:0]   key_id;
    logic [GRADE_W-1:0] grade;
    logic               insured;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage
`default_nettype wire

>>> hdl/dkpq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
`default_nettype none
module dkpq_ram #(
  parameter int WIDTH = 39,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/descending_key_priority_queue_top.sv
// Top level: sorted priority queue held in one RAM, largest key at the highest used slot.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_op, in_key_id, in_grade, in_insured
//   out_     output     out_valid / out_stall out_status, out_key_id, out_grade, out_insured
//
// Dequeue goes through S_DQW to S_FIN; dequeue on empty, enqueue on full or into an empty
// queue go straight to S_FIN. Enqueue scans in S_SCAN: the insert scan moves one entry per
// cycle through the RAM read port, from the front slot down to the insertion point.
// Synchronous active-low reset clears the count and control; RAM contents are not cleared.
// A new transaction is taken while a result waits on out_stall; it finishes up to its
// result and holds there until the output register is free.
`default_nettype none
module descending_key_priority_queue_top #(
  parameter int DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_op,
  input  wire logic [dkpq_pkg::KEY_W-1:0]   in_key_id,
  input  wire logic [dkpq_pkg::GRADE_W-1:0] in_grade,
  input  wire logic                        in_insured,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [dkpq_pkg::STAT_W-1:0]       out_status,
  output logic [dkpq_pkg::KEY_W-1:0]        out_key_id,
  output logic [dkpq_pkg::GRADE_W-1:0]      out_grade,
  output logic                             out_insured
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DQW   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_PLACE = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [AW-1:0]               idx_r, idx_nxt;
  dkpq_pkg::rec_t              rec_r, rec_nxt;
  dkpq_pkg::rec_t              res_rec_r, res_rec_nxt;
  logic [dkpq_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic                        out_valid_r, out_valid_nxt;
  dkpq_pkg::rec_t              out_rec_r, out_rec_nxt;
  logic [dkpq_pkg::STAT_W-1:0] out_status_r, out_status_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [AW-1:0]               ram_raddr;
  dkpq_pkg::rec_t              ram_wdata;
  dkpq_pkg::rec_t              ram_rdata;
  logic [dkpq_pkg::REC_W-1:0]  ram_rdata_raw;

  logic                        accept;
  logic                        out_free;
  logic [CW-1:0]               cnt_m1;

  dkpq_ram #(
    .WIDTH (dkpq_pkg::REC_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = ram_rdata_raw;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cnt_m1    = cnt_r - CW'(1);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    rec_nxt        = rec_r;
    res_rec_nxt    = res_rec_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_rec_nxt    = out_rec_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = rec_r;
    ram_raddr      = idx_r - AW'(1);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          rec_nxt        = '{key_id: in_key_id, grade: in_grade, insured: in_insured};
          res_rec_nxt    = '0;
          res_status_nxt = dkpq_pkg::ST_DONE;
          if (in_op == dkpq_pkg::OP_DEQ) begin
            if (cnt_r == '0) begin
              res_status_nxt = dkpq_pkg::ST_EMPTY;
              state_nxt      = S_FIN;
            end else begin
              ram_raddr = cnt_m1[AW-1:0];
              state_nxt = S_DQW;
            end
          end else begin
            if (cnt_r == FULL_CNT) begin
              res_status_nxt = dkpq_pkg::ST_FULL;
              state_nxt      = S_FIN;
            end else if (cnt_r == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = '{key_id: in_key_id, grade: in_grade, insured: in_insured};
              cnt_nxt   = cnt_r + CW'(1);
              state_nxt = S_FIN;
            end else begin
              ram_raddr = cnt_m1[AW-1:0];
              idx_nxt   = cnt_m1[AW-1:0];
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_DQW: begin
        res_rec_nxt = ram_rdata;
        cnt_nxt     = cnt_m1;
        state_nxt   = S_FIN;
      end
      S_SCAN: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r + AW'(1);
        if (ram_rdata.key_id > rec_r.key_id) begin
          ram_wdata = ram_rdata;
          if (idx_r == '0) begin
            state_nxt = S_PLACE;
          end else begin
            idx_nxt   = idx_r - AW'(1);
            ram_raddr = idx_r - AW'(1);
          end
        end else begin
          ram_wdata = rec_r;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_FIN;
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = rec_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_rec_nxt    = res_rec_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    rec_r        <= rec_nxt;
    res_rec_r    <= res_rec_nxt;
    res_status_r <= res_status_nxt;
    out_rec_r    <= out_rec_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_key_id  = out_rec_r.key_id;
  assign out_grade   = out_rec_r.grade;
  assign out_insured = out_rec_r.insured;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("entry count above depth");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ({1'b0, ram_waddr} <= {1'b0, cnt_r}) && (cnt_r != FULL_CNT))
    else $error("RAM write beyond the filled region");

  a_scan_below_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ({1'b0, idx_r} < {1'b0, cnt_r}))
    else $error("insert scan index outside stored entries");

  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && out_free |=> out_valid_r && (state_r == S_IDLE))
    else $error("finished transaction not presented");
`endif

endmodule
`default_nettype wire

>>> tb/descending_key_priority_queue_top_tb.sv
// Testbench for the descending-key priority queue: directed and random traffic vs. a predictor.
`timescale 1ns / 1ps
module descending_key_priority_queue_top_tb;

  localparam int QUEUE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 2 * QUEUE_DEPTH + 16;
  localparam int MAX_REPORTS = 200;
  localparam logic [dkpq_pkg::KEY_W-1:0]   KEY_MAX   = '1;
  localparam logic [dkpq_pkg::GRADE_W-1:0] GRADE_MAX = '1;
  localparam logic [dkpq_pkg::GRADE_W-1:0] GRADE_TOP = 7'd100;

  typedef struct {
    logic [dkpq_pkg::STAT_W-1:0]  status;
    logic [dkpq_pkg::KEY_W-1:0]   key_id;
    logic [dkpq_pkg::GRADE_W-1:0] grade;
    logic                         insured;
  } reply_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_op;
  logic [dkpq_pkg::KEY_W-1:0]   in_key_id;
  logic [dkpq_pkg::GRADE_W-1:0] in_grade;
  logic                         in_insured;
  logic                         out_valid;
  logic                         out_stall;
  logic [dkpq_pkg::STAT_W-1:0]  out_status;
  logic [dkpq_pkg::KEY_W-1:0]   out_key_id;
  logic [dkpq_pkg::GRADE_W-1:0] out_grade;
  logic                         out_insured;

  dkpq_pkg::rec_t sorted_recs[QUEUE_DEPTH];
  int unsigned    held_count;
  reply_t         expected_replies[$];
  int unsigned    mismatch_count;
  int unsigned    cycle_count;
  int unsigned    stall_left;
  bit             src_idle_on;
  bit             sink_idle_on;

  descending_key_priority_queue_top #(
    .DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_key_id  (in_key_id),
    .in_grade   (in_grade),
    .in_insured (in_insured),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_key_id (out_key_id),
    .out_grade  (out_grade),
    .out_insured(out_insured)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic reply_t queue_outcome(input logic op,
                                           input logic [dkpq_pkg::KEY_W-1:0] key,
                                           input logic [dkpq_pkg::GRADE_W-1:0] grade,
                                           input logic insured);
    reply_t      r;
    int unsigned pos;
    int unsigned idx;
    r.status  = dkpq_pkg::ST_DONE;
    r.key_id  = '0;
    r.grade   = '0;
    r.insured = 1'b0;
    if (op == dkpq_pkg::OP_ENQ) begin
      if (held_count >= QUEUE_DEPTH) begin
        r.status = dkpq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && sorted_recs[pos].key_id > key) pos++;
        for (idx = held_count; idx > pos; idx--) sorted_recs[idx] = sorted_recs[idx - 1];
        sorted_recs[pos] = {key, grade, insured};
        held_count++;
      end
    end else if (held_count == 0) begin
      r.status = dkpq_pkg::ST_EMPTY;
    end else begin
      r.key_id  = sorted_recs[0].key_id;
      r.grade   = sorted_recs[0].grade;
      r.insured = sorted_recs[0].insured;
      for (idx = 1; idx < held_count; idx++) sorted_recs[idx - 1] = sorted_recs[idx];
      held_count--;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      if (mismatch_count < MAX_REPORTS)
        $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic logic [dkpq_pkg::KEY_W-1:0] rand_key();
    logic [dkpq_pkg::KEY_W-1:0] k;
    case ($urandom_range(0, 7))
      0, 1, 2: k = dkpq_pkg::KEY_W'($urandom());
      3, 4:    k = dkpq_pkg::KEY_W'($urandom_range(0, 15));
      5:       k = KEY_MAX - dkpq_pkg::KEY_W'($urandom_range(0, 3));
      6:       k = dkpq_pkg::KEY_W'($urandom_range(0, 3));
      default: k = $urandom_range(0, 1) ? KEY_MAX : '0;
    endcase
    return k;
  endfunction

  // result side: compare each result in order, then a random stall when sink_idle_on is set
  always @(posedge clk) begin : sink_side
    reply_t want;
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          if (mismatch_count < MAX_REPORTS)
            $error("result with no transaction pending: status %0d key_id %0d",
                   out_status, out_key_id);
          mismatch_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("out_key_id", 32'(want.key_id), 32'(out_key_id));
          check_field("out_grade", 32'(want.grade), 32'(out_grade));
          check_field("out_insured", 32'(want.insured), 32'(out_insured));
        end
        stall_left = sink_idle_on ? $urandom_range(0, 9) : 0;
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  task automatic send_op(input logic op, input logic [dkpq_pkg::KEY_W-1:0] key,
                         input logic [dkpq_pkg::GRADE_W-1:0] grade, input logic insured);
    int unsigned gap;
    gap = src_idle_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_key_id  <= key;
    in_grade   <= grade;
    in_insured <= insured;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_replies.push_back(queue_outcome(op, key, grade, insured));
  endtask

  task automatic send_enqueue(input logic [dkpq_pkg::KEY_W-1:0] key);
    send_op(dkpq_pkg::OP_ENQ, key, dkpq_pkg::GRADE_W'($urandom_range(0, 127)),
            1'($urandom_range(0, 1)));
  endtask

  task automatic send_dequeue();
    send_op(dkpq_pkg::OP_DEQ, dkpq_pkg::KEY_W'($urandom()),
            dkpq_pkg::GRADE_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
  endtask

  task automatic settle_queue();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_replies.size() != 0);
  endtask

  task automatic test_empty_dequeue();
    send_op(dkpq_pkg::OP_DEQ, KEY_MAX, GRADE_MAX, 1'b1);
    send_op(dkpq_pkg::OP_DEQ, '0, '0, 1'b0);
  endtask

  task automatic test_field_extremes();
    send_op(dkpq_pkg::OP_ENQ, '0, '0, 1'b0);
    send_op(dkpq_pkg::OP_ENQ, KEY_MAX, GRADE_MAX, 1'b1);
    send_op(dkpq_pkg::OP_ENQ, 31'd1, GRADE_TOP, 1'b1);
    send_op(dkpq_pkg::OP_ENQ, KEY_MAX - dkpq_pkg::KEY_W'(1), 7'd101, 1'b0);
    send_op(dkpq_pkg::OP_DEQ, 31'h2AAA_AAAA, 7'h55, 1'b1);
    send_op(dkpq_pkg::OP_DEQ, '0, '0, 1'b0);
    send_op(dkpq_pkg::OP_DEQ, KEY_MAX, GRADE_MAX, 1'b1);
    send_op(dkpq_pkg::OP_DEQ, 31'h5555_5555, 7'h2A, 1'b0);
    send_op(dkpq_pkg::OP_DEQ, '0, '0, 1'b0);
  endtask

  task automatic test_equal_keys();
    send_op(dkpq_pkg::OP_ENQ, 31'd5, 7'd10, 1'b0);
    send_op(dkpq_pkg::OP_ENQ, 31'd5, 7'd20, 1'b1);
    send_op(dkpq_pkg::OP_ENQ, 31'd9, 7'd30, 1'b0);
    send_op(dkpq_pkg::OP_ENQ, 31'd5, 7'd40, 1'b1);
    send_op(dkpq_pkg::OP_ENQ, 31'd4, 7'd50, 1'b0);
    repeat (6) send_dequeue();
  endtask

  task automatic test_full_queue();
    repeat (QUEUE_DEPTH + 3) send_enqueue(rand_key());
    repeat (QUEUE_DEPTH + 2) send_dequeue();
    settle_queue();
  endtask

  task automatic test_random_mix(input int unsigned item_goal);
    int unsigned sent;
    int unsigned phase_len;
    int unsigned enq_pct;
    sent = 0;
    while (sent < item_goal) begin
      case ($urandom_range(0, 3))
        0:       enq_pct = 80;
        1:       enq_pct = 25;
        default: enq_pct = 55;
      endcase
      src_idle_on  = $urandom_range(0, 3) != 0;
      sink_idle_on = $urandom_range(0, 3) != 0;
      phase_len    = $urandom_range(40, 160);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < enq_pct) send_enqueue(rand_key());
        else send_dequeue();
      end
      sent += phase_len;
      if ($urandom_range(0, 2) == 0) settle_queue();
    end
    settle_queue();
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    held_count     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    stall_left     = 0;
    src_idle_on    = 1'b1;
    sink_idle_on   = 1'b1;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_op      <= dkpq_pkg::OP_ENQ;
    in_key_id  <= '0;
    in_grade   <= '0;
    in_insured <= 1'b0;
    out_stall  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_dequeue();
    test_field_extremes();
    test_equal_keys();
    settle_queue();

    src_idle_on  = 1'b0;
    sink_idle_on = 1'b1;
    test_full_queue();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b0;
    test_full_queue();

    test_random_mix(1500);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
